[rtl/arcball_rotation_accumulator_unit_defines.svh]
// Assertion macros for the arcball rotation accumulator.
// Taken by the checker; depends on clk and arst_n in the including scope.
`ifndef ARCBALL_ROTATION_ACCUMULATOR_UNIT_DEFINES_SVH
`define ARCBALL_ROTATION_ACCUMULATOR_UNIT_DEFINES_SVH

// next-cycle implication, masked while reset is asserted
`define ARAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arau check failed");

// same-cycle implication, also active during reset
`define ARAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("arau check failed");

`endif

[rtl/arau_pkg.sv]
// Shared types and constants of the arcball rotation accumulator.
// No dependencies; used by the top level and the back end.
package arau_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BALL_RADIUS   = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;
	localparam int SIZE_W    = 13;
	localparam int RAD_W     = 15;
	localparam int OUT_W     = 16;
	localparam int MAT_N     = 9;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [RAD_W-1:0]  RADIUS_RST = 15'd16384;

	// live configuration handed to the back end
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic [RAD_W-1:0]  radius;
	} cfg_t;

endpackage

[rtl/arau_front.sv]
// Front end: takes drag beats and holds them in a two-entry queue.
// No package dependency; feeds arau_back.
module arau_front #(
	parameter int IW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [IW-1:0] in_data,
	output logic          q_valid,
	input  logic          q_pop,
	output logic [IW-1:0] q_data
);
	logic [IW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_data   = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_data;
	end
endmodule

[rtl/arau_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No package dependency; shared by the back end.
module arau_div #(
	parameter int DW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [DW-1:0] quo
);
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DW:0]     cand;
	logic [DW:0]     trial;

	assign cand  = {rem_q, quo_q[DW-1]};
	assign trial = cand - {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(DW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= cand[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end
endmodule

[rtl/arau_sqrt.sv]
// Floor integer square root, one root bit per cycle.
// No package dependency; shared by the back end.
module arau_sqrt #(
	parameter int SW = 36
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SW-1:0]   op,
	output logic            done,
	output logic [SW/2-1:0] root
);
	localparam int HW   = SW / 2;
	localparam int CNTW = $clog2(HW + 1);

	logic [SW-1:0]   op_q;
	logic [HW+1:0]   rem_q;
	logic [HW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [HW+3:0]   cur;
	logic [HW+3:0]   trl;

	assign cur  = {rem_q, op_q[SW-1:SW-2]};
	assign trl  = (HW+4)'({root_q, 2'b01});
	assign done = done_q;
	assign root = root_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(HW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// two operand bits per step
	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			op_q <= {op_q[SW-3:0], 2'b00};
			if (cur >= trl) begin
				rem_q  <= (HW+2)'(cur - trl);
				root_q <= {root_q[HW-2:0], 1'b1};
			end else begin
				rem_q  <= cur[HW+1:0];
				root_q <= {root_q[HW-2:0], 1'b0};
			end
		end
	end
endmodule

[rtl/arau_back.sv]
// Back end: sequencer that lifts both points, builds the rotation and
// accumulates it. Uses arau_pkg, arau_div and arau_sqrt.
module arau_back import arau_pkg::*; #(
	parameter int FRAC_BITS  = 14,
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  logic [4*COORD_BITS-1:0] q_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] res [MAT_N]
);
	localparam int F     = FRAC_BITS;
	localparam int C     = COORD_BITS;
	localparam int XW    = F + 5;
	localparam int ZW    = F + 2;
	localparam int VW    = F + 2;
	localparam int CW    = F + 3;
	localparam int RQW   = F + 4;
	localparam int MW    = F + 2;
	localparam int PW    = F + 5;
	localparam int NW    = F + 4;
	localparam int SW    = 2 * F + 8;
	localparam int R2W   = 2 * F + 2;
	localparam int RW    = F + 1;
	localparam int DW    = (C + F + 2 > 2 * F + 4) ? C + F + 2 : 2 * F + 4;
	localparam int WW    = 2 * F + 16;
	localparam int RSH_L = (F >= 14) ? F - 14 : 0;
	localparam int RSH_R = (F >= 14) ? 0 : 14 - F;

	typedef logic signed [WW-1:0] wide_t;

	localparam wide_t ONE     = wide_t'(1) <<< F;
	localparam wide_t LIM_NDC = ONE <<< 3;
	localparam wide_t LIM_ROT = ONE <<< 2;

	// sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_R2   = 5'd1;
	localparam logic [4:0] S_NX   = 5'd2;
	localparam logic [4:0] S_NXW  = 5'd3;
	localparam logic [4:0] S_NY   = 5'd4;
	localparam logic [4:0] S_NYW  = 5'd5;
	localparam logic [4:0] S_SXX  = 5'd6;
	localparam logic [4:0] S_SYY  = 5'd7;
	localparam logic [4:0] S_ZB   = 5'd8;
	localparam logic [4:0] S_ZSW  = 5'd9;
	localparam logic [4:0] S_ZHW  = 5'd10;
	localparam logic [4:0] S_ZDW  = 5'd11;
	localparam logic [4:0] S_ZZ   = 5'd12;
	localparam logic [4:0] S_NS   = 5'd13;
	localparam logic [4:0] S_NSW  = 5'd14;
	localparam logic [4:0] S_VS   = 5'd15;
	localparam logic [4:0] S_VW   = 5'd16;
	localparam logic [4:0] S_PNX  = 5'd17;
	localparam logic [4:0] S_CR1  = 5'd18;
	localparam logic [4:0] S_CR2  = 5'd19;
	localparam logic [4:0] S_DT   = 5'd20;
	localparam logic [4:0] S_CHK  = 5'd21;
	localparam logic [4:0] S_RM   = 5'd22;
	localparam logic [4:0] S_RD   = 5'd23;
	localparam logic [4:0] S_RWT  = 5'd24;
	localparam logic [4:0] S_RF   = 5'd25;
	localparam logic [4:0] S_MM   = 5'd26;
	localparam logic [4:0] S_MC   = 5'd27;
	localparam logic [4:0] S_OUT  = 5'd28;

	// round half away from zero, then drop F fraction bits
	function automatic wide_t rnd(input wide_t v);
		wide_t half;
		half = ONE >>> 1;
		if (v >= 0)
			rnd = (v + half) >>> F;
		else
			rnd = -(((-v) + half) >>> F);
	endfunction

	function automatic wide_t clampw(input wide_t v, input wide_t lim);
		if (v > lim)
			clampw = lim;
		else if (v < -lim)
			clampw = -lim;
		else
			clampw = v;
	endfunction

	function automatic logic [1:0] nxt(input logic [1:0] k);
		nxt = (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

	// unique pairs of the symmetric outer product
	function automatic logic [1:0] pair_i(input logic [2:0] p);
		unique case (p)
			3'd0, 3'd1, 3'd2: pair_i = 2'd0;
			3'd3, 3'd4:       pair_i = 2'd1;
			default:          pair_i = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] pair_j(input logic [2:0] p);
		unique case (p)
			3'd0:       pair_j = 2'd0;
			3'd1, 3'd3: pair_j = 2'd1;
			default:    pair_j = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] e_row(input logic [3:0] e);
		if (e < 4'd3)
			e_row = 2'd0;
		else if (e < 4'd6)
			e_row = 2'd1;
		else
			e_row = 2'd2;
	endfunction

	logic [4:0]              state_q;
	logic                    pt_q;
	logic [1:0]              k_q;
	logic [3:0]              e_q;
	logic [2:0]              p_q;
	logic                    out_valid_q;
	logic signed [MW-1:0]    mat_q [MAT_N];

	logic [4*C-1:0]          item_q;
	logic [R2W-1:0]          r2_q;
	logic signed [XW-1:0]    x_q;
	logic signed [XW-1:0]    y_q;
	logic [SW-1:0]           s_q;
	logic [ZW-1:0]           z_q;
	logic [NW-1:0]           n_q;
	logic signed [VW-1:0]    vec_q [2][3];
	logic signed [CW-1:0]    c_q [3];
	logic signed [VW-1:0]    d_q;
	wide_t                   acc_q;
	logic signed [RQW-1:0]   rot_q [MAT_N];
	logic signed [MW-1:0]    nm_q [MAT_N];
	logic signed [OUT_W-1:0] res_q [MAT_N];

	logic [SIZE_W-1:0]       w_den;
	logic [SIZE_W-1:0]       h_den;
	logic [RW-1:0]           r_val;
	logic [C-1:0]            px;
	logic [C-1:0]            py;
	logic [XW-1:0]           comp_mag;
	logic                    comp_neg;
	wide_t                   acc_abs;
	wide_t                   q_w;
	wide_t                   den_w;
	logic signed [PW-1:0]    mul_a;
	logic signed [PW-1:0]    mul_b;
	logic signed [2*PW-1:0]  prod_full;
	wide_t                   prod;
	wide_t                   acc_sum;
	logic [1:0]              pi;
	logic [1:0]              pj;
	logic [1:0]              ro;
	logic [1:0]              co;
	logic [3:0]              idx_ij;
	logic [3:0]              idx_ji;
	logic [3:0]              mm_a;
	logic [3:0]              mm_b;
	logic                    c_nz;
	logic                    out_free;
	logic signed [RQW-1:0]   rot_fix [MAT_N];

	logic                    div_start;
	logic [DW-1:0]           div_num;
	logic [DW-1:0]           div_den;
	logic                    div_done;
	logic [DW-1:0]           div_quo;
	logic                    sq_start;
	logic [SW-1:0]           sq_op;
	logic                    sq_done;
	logic [NW-1:0]           sq_root;

	arau_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	arau_sqrt #(.SW(SW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.op     (sq_op),
		.done   (sq_done),
		.root   (sq_root)
	);

	// operand decode
	assign w_den    = (cfg.width == '0) ? SIZE_W'(1) : cfg.width;
	assign h_den    = (cfg.height == '0) ? SIZE_W'(1) : cfg.height;
	assign r_val    = RW'((32'(cfg.radius) << RSH_L) >> RSH_R);
	assign px       = pt_q ? item_q[2*C-1 -: C] : item_q[4*C-1 -: C];
	assign py       = pt_q ? item_q[C-1:0] : item_q[3*C-1 -: C];
	assign acc_abs  = (acc_q < 0) ? -acc_q : acc_q;
	assign q_w      = wide_t'(div_quo);
	assign den_w    = ONE + wide_t'(d_q);
	assign pi       = pair_i(p_q);
	assign pj       = pair_j(p_q);
	assign ro       = e_row(e_q);
	assign co       = 2'(e_q - 4'(ro) * 4'd3);
	assign idx_ij   = 4'(pi) * 4'd3 + 4'(pj);
	assign idx_ji   = 4'(pj) * 4'd3 + 4'(pi);
	assign mm_a     = 4'(ro) * 4'd3 + 4'(k_q);
	assign mm_b     = 4'(k_q) * 4'd3 + 4'(co);
	assign c_nz     = (c_q[0] != '0) || (c_q[1] != '0) || (c_q[2] != '0);
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign res      = res_q;

	// component for the normalising division
	always_comb begin
		unique case (k_q)
			2'd0: begin
				comp_mag = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
				comp_neg = x_q[XW-1];
			end
			2'd1: begin
				comp_mag = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
				comp_neg = y_q[XW-1];
			end
			default: begin
				comp_mag = XW'(z_q);
				comp_neg = 1'b0;
			end
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_R2: begin
				mul_a = PW'({1'b0, r_val});
				mul_b = PW'({1'b0, r_val});
			end
			S_SXX: begin
				mul_a = PW'(x_q);
				mul_b = PW'(x_q);
			end
			S_SYY: begin
				mul_a = PW'(y_q);
				mul_b = PW'(y_q);
			end
			S_ZZ: begin
				mul_a = PW'({1'b0, z_q});
				mul_b = PW'({1'b0, z_q});
			end
			S_CR1: begin
				mul_a = PW'(vec_q[0][nxt(k_q)]);
				mul_b = PW'(vec_q[1][nxt(nxt(k_q))]);
			end
			S_CR2: begin
				mul_a = PW'(vec_q[0][nxt(nxt(k_q))]);
				mul_b = PW'(vec_q[1][nxt(k_q)]);
			end
			S_DT: begin
				mul_a = PW'(vec_q[0][k_q]);
				mul_b = PW'(vec_q[1][k_q]);
			end
			S_RM: begin
				mul_a = PW'(c_q[pi]);
				mul_b = PW'(c_q[pj]);
			end
			S_MM: begin
				mul_a = PW'(rot_q[mm_a]);
				mul_b = PW'(mat_q[mm_b]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_full = mul_a * mul_b;
	assign prod      = wide_t'(prod_full);
	assign acc_sum   = (k_q == 2'd0) ? prod : acc_q + prod;

	// divider and root requests
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		sq_start  = 1'b0;
		sq_op     = '0;
		unique case (state_q)
			S_NX: begin
				div_start = 1'b1;
				div_num   = (DW'(px) << (F + 1)) + DW'(w_den >> 1);
				div_den   = DW'(w_den);
			end
			S_NY: begin
				div_start = 1'b1;
				div_num   = (DW'(py) << (F + 1)) + DW'(h_den >> 1);
				div_den   = DW'(h_den);
			end
			S_ZB: begin
				sq_start = 1'b1;
				if ((wide_t'(s_q) <<< 1) <= wide_t'(r2_q))
					sq_op = SW'(r2_q) - s_q;
				else
					sq_op = s_q;
			end
			S_ZHW: begin
				div_start = sq_done;
				div_num   = DW'(r2_q);
				div_den   = DW'({sq_root, 1'b0});
			end
			S_NS: begin
				sq_start = 1'b1;
				sq_op    = s_q;
			end
			S_VS: begin
				div_start = 1'b1;
				div_num   = DW'(comp_mag) << F;
				div_den   = DW'(n_q);
			end
			S_RD: begin
				div_start = 1'b1;
				div_num   = DW'(acc_abs);
				div_den   = DW'(den_w);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// add the diagonal and the negated cross-product matrix
	always_comb begin
		for (int i = 0; i < MAT_N; i++) begin
			wide_t t;
			t = wide_t'(rot_q[i]);
			if (i == 0 || i == 4 || i == 8)
				t = t + wide_t'(d_q);
			unique case (i)
				1:       t = t + wide_t'(c_q[2]);
				2:       t = t - wide_t'(c_q[1]);
				3:       t = t - wide_t'(c_q[2]);
				5:       t = t + wide_t'(c_q[0]);
				6:       t = t + wide_t'(c_q[1]);
				7:       t = t - wide_t'(c_q[0]);
				default: t = t;
			endcase
			rot_fix[i] = RQW'(clampw(t, ONE));
		end
	end

	// sequencer, counters, accumulated matrix and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pt_q        <= 1'b0;
			k_q         <= 2'd0;
			e_q         <= 4'd0;
			p_q         <= 3'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAT_N; i++)
				mat_q[i] <= (i % 4 == 0) ? MW'(ONE) : '0;
		end else begin
			// result beat offered from S_OUT, dropped once taken
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					pt_q    <= 1'b0;
					state_q <= S_R2;
				end
				S_R2:  state_q <= S_NX;
				S_NX:  state_q <= S_NXW;
				S_NXW: if (div_done) state_q <= S_NY;
				S_NY:  state_q <= S_NYW;
				S_NYW: if (div_done) state_q <= S_SXX;
				S_SXX: state_q <= S_SYY;
				S_SYY: state_q <= S_ZB;
				S_ZB: begin
					if ((wide_t'(s_q) <<< 1) <= wide_t'(r2_q))
						state_q <= S_ZSW;
					else
						state_q <= S_ZHW;
				end
				S_ZSW: if (sq_done) state_q <= S_ZZ;
				S_ZHW: if (sq_done) state_q <= S_ZDW;
				S_ZDW: if (div_done) state_q <= S_ZZ;
				S_ZZ:  state_q <= S_NS;
				S_NS:  state_q <= S_NSW;
				S_NSW: if (sq_done) begin
					k_q     <= 2'd0;
					state_q <= (sq_root == '0) ? S_PNX : S_VS;
				end
				S_VS: state_q <= S_VW;
				S_VW: if (div_done) begin
					if (k_q == 2'd2) begin
						state_q <= S_PNX;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_VS;
					end
				end
				S_PNX: begin
					k_q <= 2'd0;
					if (!pt_q) begin
						pt_q    <= 1'b1;
						state_q <= S_NX;
					end else begin
						state_q <= S_CR1;
					end
				end
				S_CR1: state_q <= S_CR2;
				S_CR2: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_DT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_CR1;
					end
				end
				S_DT: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_CHK;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_CHK: begin
					p_q     <= 3'd0;
					state_q <= (c_nz && den_w > 0) ? S_RM : S_OUT;
				end
				S_RM:  state_q <= S_RD;
				S_RD:  state_q <= S_RWT;
				S_RWT: if (div_done) begin
					if (p_q == 3'd5) begin
						state_q <= S_RF;
					end else begin
						p_q     <= p_q + 3'd1;
						state_q <= S_RM;
					end
				end
				S_RF: begin
					e_q     <= 4'd0;
					k_q     <= 2'd0;
					state_q <= S_MM;
				end
				S_MM: begin
					if (k_q == 2'd2) begin
						k_q <= 2'd0;
						if (e_q == 4'd8)
							state_q <= S_MC;
						else
							e_q <= e_q + 4'd1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_MC: begin
					for (int i = 0; i < MAT_N; i++)
						mat_q[i] <= nm_q[i];
					state_q <= S_OUT;
				end
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (q_valid) item_q <= q_data;
			S_R2:   r2_q <= R2W'(prod);
			S_NXW:  if (div_done) x_q <= XW'(clampw(q_w - ONE, LIM_NDC));
			S_NYW:  if (div_done) y_q <= XW'(clampw(ONE - q_w, LIM_NDC));
			S_SXX:  s_q <= SW'(prod);
			S_SYY:  s_q <= s_q + SW'(prod);
			S_ZSW:  if (sq_done) z_q <= ZW'(sq_root);
			S_ZDW:  if (div_done) z_q <= ZW'(div_quo);
			S_ZZ:   s_q <= s_q + SW'(prod);
			S_NSW: if (sq_done) begin
				n_q <= sq_root;
				if (sq_root == '0)
					for (int i = 0; i < 3; i++)
						vec_q[pt_q][i] <= '0;
			end
			S_VW: if (div_done)
				vec_q[pt_q][k_q] <= VW'(comp_neg ? -q_w : q_w);
			S_CR1: acc_q <= prod;
			S_CR2: c_q[k_q] <= CW'(rnd(acc_q - prod));
			S_DT: begin
				acc_q <= acc_sum;
				if (k_q == 2'd2)
					d_q <= VW'(clampw(rnd(acc_sum), ONE));
			end
			S_RM: acc_q <= prod;
			S_RWT: if (div_done) begin
				rot_q[idx_ij] <= RQW'(clampw((acc_q < 0) ? -q_w : q_w, LIM_ROT));
				if (idx_ji != idx_ij)
					rot_q[idx_ji] <= RQW'(clampw((acc_q < 0) ? -q_w : q_w, LIM_ROT));
			end
			S_RF: begin
				for (int i = 0; i < MAT_N; i++)
					rot_q[i] <= rot_fix[i];
			end
			S_MM: begin
				acc_q <= acc_sum;
				if (k_q == 2'd2)
					nm_q[e_q] <= MW'(clampw(rnd(acc_sum), ONE));
			end
			S_OUT: if (out_free) begin
				for (int i = 0; i < MAT_N; i++)
					res_q[i] <= OUT_W'(mat_q[i]);
			end
			default: begin
			end
		endcase
	end
endmodule

[rtl/arcball_rotation_accumulator_unit.sv]
// Arcball rotation accumulator: one drag beat in, the accumulated 3x3 matrix out.
// Processing is set by the bit-serial divider and root; one beat is in flight at a time,
// and two more beats may queue in the front end.
// Reset (arst_n low, async) clears the queue, restores identity, 640x480, unit radius.
module arcball_rotation_accumulator_unit import arau_pkg::*; #(
	parameter int FRAC_BITS  = 14,
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   cur_x,
	input  logic [COORD_BITS-1:0]   cur_y,
	input  logic [COORD_BITS-1:0]   prev_x,
	input  logic [COORD_BITS-1:0]   prev_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] m00,
	output logic signed [OUT_W-1:0] m01,
	output logic signed [OUT_W-1:0] m02,
	output logic signed [OUT_W-1:0] m10,
	output logic signed [OUT_W-1:0] m11,
	output logic signed [OUT_W-1:0] m12,
	output logic signed [OUT_W-1:0] m20,
	output logic signed [OUT_W-1:0] m21,
	output logic signed [OUT_W-1:0] m22,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data
);
	localparam int IW = 4 * COORD_BITS;

	cfg_t                    cfg_q;
	logic                    q_valid;
	logic                    q_pop;
	logic [IW-1:0]           q_data;
	logic signed [OUT_W-1:0] res [MAT_N];

	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
			cfg_q.radius <= RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.width  <= cfg_data[SIZE_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.height <= cfg_data[SIZE_W-1:0];
				REG_BALL_RADIUS:   cfg_q.radius <= cfg_data[RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	arau_front #(.IW(IW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  ({cur_x, cur_y, prev_x, prev_y}),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data)
	);

	arau_back #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign m00 = res[0];
	assign m01 = res[1];
	assign m02 = res[2];
	assign m10 = res[3];
	assign m11 = res[4];
	assign m12 = res[5];
	assign m20 = res[6];
	assign m21 = res[7];
	assign m22 = res[8];
endmodule

[rtl/arau_checker.sv]
// Port-level checks for the arcball rotation accumulator, bound to the top level.
// Depends on arcball_rotation_accumulator_unit_defines.svh.
`include "arcball_rotation_accumulator_unit_defines.svh"

module arau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] m00,
	input logic signed [15:0] m01,
	input logic signed [15:0] m02,
	input logic signed [15:0] m10,
	input logic signed [15:0] m11,
	input logic signed [15:0] m12,
	input logic signed [15:0] m20,
	input logic signed [15:0] m21,
	input logic signed [15:0] m22
);
	logic [143:0] mat_bits;

	assign mat_bits = {m00, m01, m02, m10, m11, m12, m20, m21, m22};

	// a waiting result beat stays offered
	`ARAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// and its matrix does not move
	`ARAU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(mat_bits))
	// reset drops any pending result
	`ARAU_ASSERT_NOW(a_rst_out, !arst_n, !out_valid)
	// reset empties the input queue
	`ARAU_ASSERT_NOW(a_rst_in, !arst_n, !in_stall)
endmodule

bind arcball_rotation_accumulator_unit arau_checker u_arau_checker (.*);
